### sv/bspf_pkg.sv
// Shared constants and types for the buffered serial port FIFO control.
package bspf_pkg;

  localparam int TX_DEPTH = 64;
  localparam int RX_DEPTH = 16;
  localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);

  // Host-side action codes
  localparam logic [2:0] ACT_PUSH  = 3'd0;
  localparam logic [2:0] ACT_PULL  = 3'd1;
  localparam logic [2:0] ACT_RECV  = 3'd2;
  localparam logic [2:0] ACT_READY = 3'd3;
  localparam logic [2:0] ACT_DONE  = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH,
    OP_PULL,
    OP_RECV,
    OP_READY,
    OP_DONE
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    op_t  op;
  } cmd_t;

  function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
    tx_inc = (p == TX_LAST) ? '0 : p + TX_AW'(1);
  endfunction

  function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
    rx_inc = (p == RX_LAST) ? '0 : p + RX_AW'(1);
  endfunction

endpackage

### sv/buffered_serial_port_fifo_control.sv
// Top level of the buffered serial port FIFO control.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------------
//   command  | start & !busy           | action, data_byte
//   result   | done (one-cycle strobe) | accepted, read_byte, send_valid,
//            |                         | send_byte, driver_enable, rx_not_empty,
//            |                         | tx_busy
//   config   | cfg_write               | cfg_data (port_enabled)
//
// Each beat is accepted in ST_IDLE and then executed in ST_EXEC, in which the
// registered ring RAM read (issued at the read pointer) is consumed.
// The result strobe follows the execute cycle; busy is already low then,
// so a new beat may be accepted while the result is shown.
// Synchronous reset clears pointers and flags; ring memories are not cleared.
// The receiver cannot stall results.
module buffered_serial_port_fifo_control (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] action,
  input  logic [7:0] data_byte,
  input  logic       cfg_write,
  input  logic       cfg_data,
  output logic       done,
  output logic       accepted,
  output logic [7:0] read_byte,
  output logic       send_valid,
  output logic [7:0] send_byte,
  output logic       driver_enable,
  output logic       rx_not_empty,
  output logic       tx_busy
);

  bspf_pkg::cmd_t cmd;

  bspf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  bspf_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .data_byte     (data_byte),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .accepted      (accepted),
    .read_byte     (read_byte),
    .send_valid    (send_valid),
    .send_byte     (send_byte),
    .driver_enable (driver_enable),
    .rx_not_empty  (rx_not_empty),
    .tx_busy       (tx_busy)
  );

endmodule

### sv/bspf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bspf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/bspf_ctrl.sv
// Controller: accepts a beat, decodes the action and sequences execution.
module bspf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        action,
  output logic              busy,
  output logic              done,
  output bspf_pkg::cmd_t    cmd
);

  bspf_pkg::state_t state, state_next;
  bspf_pkg::op_t    op, op_next;
  logic             done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bspf_pkg::ST_IDLE;
      op    <= bspf_pkg::OP_NONE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next  = state;
    op_next     = op;
    done_next   = 1'b0;
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.op      = op;
    case (state)
      bspf_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = bspf_pkg::ST_EXEC;
          case (action)
            bspf_pkg::ACT_PUSH:  op_next = bspf_pkg::OP_PUSH;
            bspf_pkg::ACT_PULL:  op_next = bspf_pkg::OP_PULL;
            bspf_pkg::ACT_RECV:  op_next = bspf_pkg::OP_RECV;
            bspf_pkg::ACT_READY: op_next = bspf_pkg::OP_READY;
            bspf_pkg::ACT_DONE:  op_next = bspf_pkg::OP_DONE;
            default:             op_next = bspf_pkg::OP_NONE;
          endcase
        end
      end
      bspf_pkg::ST_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        done_next  = 1'b1;
        state_next = bspf_pkg::ST_IDLE;
      end
      default: begin
        state_next = bspf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### sv/bspf_dpath.sv
// Datapath: ring pointers, port flags, ring memories and result registers.
module bspf_dpath (
  input  logic           clk,
  input  logic           rst,
  input  bspf_pkg::cmd_t cmd,
  input  logic [7:0]     data_byte,
  input  logic           cfg_write,
  input  logic           cfg_data,
  output logic           accepted,
  output logic [7:0]     read_byte,
  output logic           send_valid,
  output logic [7:0]     send_byte,
  output logic           driver_enable,
  output logic           rx_not_empty,
  output logic           tx_busy
);

  logic [bspf_pkg::TX_AW-1:0] tx_wr, tx_wr_next, tx_rd, tx_rd_next, tx_wr_inc;
  logic [bspf_pkg::RX_AW-1:0] rx_wr, rx_wr_next, rx_rd, rx_rd_next, rx_wr_inc;
  logic       sending, sending_next;
  logic       waiting, waiting_next;
  logic       driver_on, driver_on_next;
  logic       done_armed, done_armed_next;
  logic       port_enabled;
  logic [7:0] data_q;
  logic       tx_we, rx_we;
  logic [7:0] tx_rdata, rx_rdata;
  logic       acc_next, sv_next;
  logic [7:0] rb_next, sb_next, tx_src;
  logic       do_start;

  bspf_ram #(.WIDTH(8), .DEPTH(bspf_pkg::TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wr),
    .wdata (data_q),
    .raddr (tx_rd),
    .rdata (tx_rdata)
  );

  bspf_ram #(.WIDTH(8), .DEPTH(bspf_pkg::RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wr),
    .wdata (data_q),
    .raddr (rx_rd),
    .rdata (rx_rdata)
  );

  assign tx_wr_inc = bspf_pkg::tx_inc(tx_wr);
  assign rx_wr_inc = bspf_pkg::rx_inc(rx_wr);
  // push into an empty ring sends the byte being written this cycle
  assign tx_src = (tx_rd == tx_wr) ? data_q : tx_rdata;

  always_comb begin
    tx_wr_next      = tx_wr;
    tx_rd_next      = tx_rd;
    rx_wr_next      = rx_wr;
    rx_rd_next      = rx_rd;
    sending_next    = sending;
    waiting_next    = waiting;
    driver_on_next  = driver_on;
    done_armed_next = done_armed;
    tx_we           = 1'b0;
    rx_we           = 1'b0;
    acc_next        = 1'b0;
    rb_next         = 8'd0;
    sv_next         = 1'b0;
    sb_next         = 8'd0;
    do_start        = 1'b0;
    if (cmd.exec) begin
      case (cmd.op)
        bspf_pkg::OP_PUSH: begin
          if (tx_wr_inc != tx_rd) begin
            tx_we      = 1'b1;
            tx_wr_next = tx_wr_inc;
            acc_next   = 1'b1;
            do_start   = !sending;
          end
        end
        bspf_pkg::OP_PULL: begin
          if (rx_wr != rx_rd) begin
            rb_next    = rx_rdata;
            rx_rd_next = bspf_pkg::rx_inc(rx_rd);
          end
          if (rx_wr == rx_rd_next) begin
            waiting_next = 1'b0;
          end
        end
        bspf_pkg::OP_RECV: begin
          if (rx_wr_inc != rx_rd) begin
            rx_we        = 1'b1;
            rx_wr_next   = rx_wr_inc;
            waiting_next = 1'b1;
            acc_next     = 1'b1;
          end
        end
        bspf_pkg::OP_READY: begin
          done_armed_next = 1'b1;
          if (tx_wr != tx_rd) begin
            do_start = 1'b1;
          end else begin
            sending_next = 1'b0;
          end
        end
        bspf_pkg::OP_DONE: begin
          if (done_armed) begin
            done_armed_next = 1'b0;
            driver_on_next  = 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (do_start) begin
        if (!port_enabled) begin
          sending_next = (cmd.op == bspf_pkg::OP_READY);
          tx_wr_next   = '0;
          tx_rd_next   = '0;
        end else begin
          sending_next   = 1'b1;
          driver_on_next = 1'b1;
          sv_next        = 1'b1;
          sb_next        = tx_src;
          tx_rd_next     = bspf_pkg::tx_inc(tx_rd);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_wr        <= '0;
      tx_rd        <= '0;
      rx_wr        <= '0;
      rx_rd        <= '0;
      sending      <= 1'b0;
      waiting      <= 1'b0;
      driver_on    <= 1'b0;
      done_armed   <= 1'b0;
      port_enabled <= 1'b0;
    end else begin
      tx_wr      <= tx_wr_next;
      tx_rd      <= tx_rd_next;
      rx_wr      <= rx_wr_next;
      rx_rd      <= rx_rd_next;
      sending    <= sending_next;
      waiting    <= waiting_next;
      driver_on  <= driver_on_next;
      done_armed <= done_armed_next;
      if (cfg_write) begin
        port_enabled <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      data_q <= data_byte;
    end
    if (cmd.exec) begin
      accepted   <= acc_next;
      read_byte  <= rb_next;
      send_valid <= sv_next;
      send_byte  <= sb_next;
    end
  end

  assign driver_enable = driver_on;
  assign rx_not_empty  = waiting;
  assign tx_busy       = sending;

endmodule
